>>> sv/smu_pkg.sv
// Shared constants, types and command codes for the sorted merge union unit.
package smu_pkg;

  // Store depth per list and derived widths
  localparam int ListDepth = 16;
  localparam int CntW      = $clog2(ListDepth + 1);
  localparam int IdxW      = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int DataW     = 32;

  // Command codes
  localparam logic [1:0] CmdAppendA = 2'd0;
  localparam logic [1:0] CmdAppendB = 2'd1;
  localparam logic [1:0] CmdRun     = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StMerge,
    StFlush
  } state_e;

  // Result of the shared head compare
  typedef struct packed {
    logic                    take_a;
    logic signed [DataW-1:0] value;
  } head_sel_t;

endpackage

>>> sv/smu_head_select.sv
// Shared head compare: picks the smaller list head, list A on ties.
module smu_head_select
  import smu_pkg::*;
(
  input  logic signed [DataW-1:0] head_a_i,
  input  logic signed [DataW-1:0] head_b_i,
  input  logic                    a_avail_i,
  input  logic                    b_avail_i,
  output head_sel_t               sel_o
);

  // Take A when B is exhausted or A's head does not exceed B's
  always_comb begin
    sel_o.take_a = a_avail_i && (!b_avail_i || (head_a_i <= head_b_i));
    sel_o.value  = sel_o.take_a ? head_a_i : head_b_i;
  end

endmodule

>>> sv/sorted_merge_union_unit.sv
// Top level of the sorted merge union unit: list stores, sequencer and result register.
//
// Usage: a command is transferred at a rising edge with start_i high and busy_o low.
// cmd_i 0 appends value_i to list A, 1 appends to list B, 2 runs the merge, 3 is ignored.
// Appends give no result; an append to a full list is dropped
// and sets the overflow flag reported on the next run's results.
// A run walks both stores through one shared compare unit, one head per cycle, and
// keeps busy_o high through the merge and the final flush state.
// Distinct values leave ascending, each shown for one cycle with valid_o high; the
// final one carries last_o and shows in the first cycle with busy_o low. A value is
// held until the next distinct value (or the end of the lists) shows whether it is
// the last, and only then is it registered into the result.
// A run on two empty lists gives one result in the following cycle with empty_res_o and
// last_o set, and busy_o stays low.
// After each run both lists and the overflow flag are cleared.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// Reset clears the counts, the flag, the sequencer and the strobe; store
// contents are undefined until written and only loaded entries are read.
module sorted_merge_union_unit
  import smu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              cmd_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    busy_o,
  output logic                    valid_o,
  output logic signed [DataW-1:0] out_value_o,
  output logic                    last_o,
  output logic                    empty_res_o,
  output logic                    overflow_o
);

  // List stores
  logic signed [DataW-1:0] list_a_q [ListDepth];
  logic signed [DataW-1:0] list_b_q [ListDepth];

  // Control state
  state_e          state_q, state_d;
  logic [CntW-1:0] count_a_q, count_b_q;
  logic [CntW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic            dropped_q;
  logic            have_prev_q, have_prev_d;
  logic signed [DataW-1:0] prev_q, prev_d;

  // Result register
  logic                    valid_q, valid_d;
  logic signed [DataW-1:0] res_value_q, res_value_d;
  logic                    res_last_q, res_last_d;
  logic                    res_empty_q, res_empty_d;
  logic                    res_ovf_q, res_ovf_d;

  // Sequencer outputs
  logic      accept;
  logic      wr_a, wr_b;
  logic      drop;
  logic      clear_lists;
  logic      a_avail, b_avail;
  head_sel_t sel;

  assign accept  = start_i && (state_q == StIdle);
  assign a_avail = ia_q < count_a_q;
  assign b_avail = ib_q < count_b_q;

  // Shared compare unit on the current heads
  smu_head_select u_head_select (
    .head_a_i  (list_a_q[ia_q[IdxW-1:0]]),
    .head_b_i  (list_b_q[ib_q[IdxW-1:0]]),
    .a_avail_i (a_avail),
    .b_avail_i (b_avail),
    .sel_o     (sel)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (cmd_i == CmdRun) &&
            ((count_a_q != '0) || (count_b_q != '0))) begin
          state_d = StMerge;
        end
      end
      StMerge: begin
        if ((ia_d >= count_a_q) && (ib_d >= count_b_q)) begin
          state_d = StFlush;
        end
      end
      StFlush: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs and datapath next values
  always_comb begin
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    drop        = 1'b0;
    clear_lists = 1'b0;
    ia_d        = ia_q;
    ib_d        = ib_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    valid_d     = 1'b0;
    res_value_d = res_value_q;
    res_last_d  = res_last_q;
    res_empty_d = res_empty_q;
    res_ovf_d   = res_ovf_q;
    unique case (state_q)
      StIdle: begin
        ia_d        = '0;
        ib_d        = '0;
        have_prev_d = 1'b0;
        if (accept) begin
          unique case (cmd_i)
            CmdAppendA: begin
              wr_a = count_a_q < CntW'(ListDepth);
              drop = !wr_a;
            end
            CmdAppendB: begin
              wr_b = count_b_q < CntW'(ListDepth);
              drop = !wr_b;
            end
            CmdRun: begin
              // Both lists empty: report the empty result straight away
              if ((count_a_q == '0) && (count_b_q == '0)) begin
                valid_d     = 1'b1;
                res_value_d = '0;
                res_last_d  = 1'b1;
                res_empty_d = 1'b1;
                res_ovf_d   = dropped_q;
                clear_lists = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      StMerge: begin
        // Advance the taken head
        if (sel.take_a) begin
          ia_d = ia_q + 1'b1;
        end else begin
          ib_d = ib_q + 1'b1;
        end
        // Release the held value once a new distinct value arrives
        if (!have_prev_q || (sel.value != prev_q)) begin
          if (have_prev_q) begin
            valid_d     = 1'b1;
            res_value_d = prev_q;
            res_last_d  = 1'b0;
            res_empty_d = 1'b0;
            res_ovf_d   = dropped_q;
          end
          prev_d      = sel.value;
          have_prev_d = 1'b1;
        end
      end
      StFlush: begin
        // Emit the held value as the final result
        valid_d     = 1'b1;
        res_value_d = prev_q;
        res_last_d  = 1'b1;
        res_empty_d = 1'b0;
        res_ovf_d   = dropped_q;
        clear_lists = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_a_q   <= '0;
      count_b_q   <= '0;
      dropped_q   <= 1'b0;
      ia_q        <= '0;
      ib_q        <= '0;
      have_prev_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      have_prev_q <= have_prev_d;
      valid_q     <= valid_d;
      if (clear_lists) begin
        count_a_q <= '0;
        count_b_q <= '0;
        dropped_q <= 1'b0;
      end else begin
        if (wr_a) count_a_q <= count_a_q + 1'b1;
        if (wr_b) count_b_q <= count_b_q + 1'b1;
        if (drop) dropped_q <= 1'b1;
      end
    end
  end

  // Payload registers and list stores
  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    res_value_q <= res_value_d;
    res_last_q  <= res_last_d;
    res_empty_q <= res_empty_d;
    res_ovf_q   <= res_ovf_d;
    if (wr_a) list_a_q[count_a_q[IdxW-1:0]] <= value_i;
    if (wr_b) list_b_q[count_b_q[IdxW-1:0]] <= value_i;
  end

  assign busy_o      = (state_q != StIdle);
  assign valid_o     = valid_q;
  assign out_value_o = res_value_q;
  assign last_o      = res_last_q;
  assign empty_res_o = res_empty_q;
  assign overflow_o  = res_ovf_q;

endmodule

>>> sv/smu_checker.sv
// Port-level checker for the sorted merge union unit, bound to the top level.
module smu_checker
  import smu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic [1:0] cmd_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       last_o,
  input logic       empty_res_o,
  input logic       overflow_o
);

  // An empty run gives a single, final result
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_res_o) |-> last_o)
    else $error("empty result without last");

  // A run transfer leads to either a busy merge or the empty result
  a_run_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CmdRun)) |=> (busy_o || valid_o))
    else $error("run transfer gave no response");

  // Results before the last appear only while the merge is in progress
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o)
    else $error("non-final result while idle");

  // The final result coincides with the unit becoming free
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("busy after final result");

  // Overflow holds across consecutive results of one run
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (!valid_o || (overflow_o == $past(overflow_o))))
    else $error("overflow changed within a run");

endmodule

bind sorted_merge_union_unit smu_checker u_smu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .cmd_i       (cmd_i),
  .busy_o      (busy_o),
  .valid_o     (valid_o),
  .last_o      (last_o),
  .empty_res_o (empty_res_o),
  .overflow_o  (overflow_o)
);
